// ===== sv/gcpb_pkg.sv =====
// Shared types, fixed-point constants and stage map for the Gaussian CDF pixel blend core.
package gcpb_pkg;

  // Default parameter values
  localparam int DIST_FRAC_BITS = 12;
  localparam int WEIGHT_BITS    = 16;

  // Q28 constants
  localparam int FRAC       = 28;
  localparam int ONE_Q      = 268435456;
  localparam int K_A1       = 68405298;
  localparam int K_A2       = -76369011;
  localparam int K_A3       = 381557846;
  localparam int K_A4       = -390077527;
  localparam int K_A5       = 284918850;
  localparam int K_P        = 87937066;
  localparam int K_INV_SQRT2 = 189812531;
  localparam int K_LOG2E    = 387270501;
  localparam int K_LN2      = 186065279;
  localparam longint U_LIMIT = 64'd6 << FRAC;

  // Horner addends, in order of use
  localparam int HORNER_ADD [4] = '{K_A4, K_A3, K_A2, K_A1};

  // ceil(2^32 / n): exact floor division by n for values below 2^28
  localparam logic [63:0] TWO32 = 64'd4294967296;
  localparam logic [32:0] RECIP [1:12] = '{
    33'(TWO32),
    33'((TWO32 + 64'd1) / 64'd2),
    33'((TWO32 + 64'd2) / 64'd3),
    33'((TWO32 + 64'd3) / 64'd4),
    33'((TWO32 + 64'd4) / 64'd5),
    33'((TWO32 + 64'd5) / 64'd6),
    33'((TWO32 + 64'd6) / 64'd7),
    33'((TWO32 + 64'd7) / 64'd8),
    33'((TWO32 + 64'd8) / 64'd9),
    33'((TWO32 + 64'd9) / 64'd10),
    33'((TWO32 + 64'd10) / 64'd11),
    33'((TWO32 + 64'd11) / 64'd12)
  };

  // Stage map of the shared pipeline
  localparam int STG_U      = 1;
  localparam int STG_DENOM  = 2;
  localparam int STG_DIV0   = 3;
  localparam int STG_DIV1   = 31;
  localparam int STG_LOG2E  = 3;
  localparam int STG_LN2    = 4;
  localparam int STG_TAY0   = 5;
  localparam int STG_TAY1   = 28;
  localparam int STG_EXP    = 29;
  localparam int STG_HORN0  = 32;
  localparam int STG_LAST   = 43;

  typedef enum logic [1:0] {
    MODE_ORIG  = 2'd0,
    MODE_FILL  = 2'd1,
    MODE_BLEND = 2'd2
  } mode_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  typedef struct packed {
    logic [7:0]         orig_blue;
    logic [7:0]         orig_green;
    logic [7:0]         orig_red;
    logic [7:0]         fill_blue;
    logic [7:0]         fill_green;
    logic [7:0]         fill_red;
    logic signed [15:0] distance_z;
    logic               band_flag;
    logic               region_flag;
    logic               inside_box;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_blue;
    logic [7:0]  out_green;
    logic [7:0]  out_red;
    logic [15:0] blend_weight;
  } out_t;

  // Working set carried down the pipeline
  typedef struct packed {
    mode_e              mode;
    logic               neg;
    logic               big;
    pix_t               orig;
    pix_t               fill;
    logic [15:0]        mag;
    logic [30:0]        u;
    logic [29:0]        denom;
    logic [29:0]        rem;
    logic [28:0]        quo;
    logic [33:0]        v;
    logic [5:0]         k;
    logic [27:0]        g;
    logic [28:0]        term;
    logic [27:0]        prod;
    logic signed [31:0] sum;
    logic [28:0]        e;
    logic signed [31:0] q;
    logic [60:0]        m;
    logic               msg;
    logic [29:0]        p29;
  } st_t;

endpackage

// ===== sv/gcpb_stage.sv =====
// One register stage of the CDF weight pipeline; the stage index selects its operation.
module gcpb_stage #(
  parameter int STAGE          = 1,
  parameter int DIST_FRAC_BITS = gcpb_pkg::DIST_FRAC_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  gcpb_pkg::st_t   data_i,
  output logic            valid_o,
  output gcpb_pkg::st_t   data_o
);

  localparam bit IsDiv  = (STAGE >= gcpb_pkg::STG_DIV0) && (STAGE <= gcpb_pkg::STG_DIV1);
  localparam bit IsTay  = (STAGE >= gcpb_pkg::STG_TAY0) && (STAGE <= gcpb_pkg::STG_TAY1);
  localparam bit IsHorn = (STAGE >= gcpb_pkg::STG_HORN0) && (STAGE <= gcpb_pkg::STG_LAST);
  localparam int TayIdx = IsTay ? (STAGE - gcpb_pkg::STG_TAY0) : 0;
  localparam int TayN   = TayIdx / 2 + 1;
  localparam bit TayMul = (TayIdx % 2) == 0;
  localparam int HornIdx = IsHorn ? (STAGE - gcpb_pkg::STG_HORN0) : 0;
  localparam int HornJ   = HornIdx / 2;
  localparam bit HornMul = (HornIdx % 2) == 0;
  localparam int HornAddIdx = (HornJ < 4) ? HornJ : 0;

  logic          valid_q;
  gcpb_pkg::st_t data_q, data_d;

  // Stage operation
  always_comb begin
    logic [43:0]        uprod;
    logic [35:0]        ushift;
    logic [60:0]        pu;
    logic [61:0]        sq;
    logic [30:0]        rs;
    logic [62:0]        wp;
    logic [55:0]        gp;
    logic [56:0]        tp;
    logic [60:0]        rp;
    logic [28:0]        nt;
    logic [28:0]        x;
    logic [31:0]        qmag;
    logic [32:0]        r;
    logic signed [33:0] rsg;
    logic signed [34:0] yv;
    logic [28:0]        y;
    uprod  = '0;
    ushift = '0;
    pu     = '0;
    sq     = '0;
    rs     = '0;
    wp     = '0;
    gp     = '0;
    tp     = '0;
    rp     = '0;
    nt     = '0;
    x      = '0;
    qmag   = '0;
    r      = '0;
    rsg    = '0;
    yv     = '0;
    y      = '0;
    data_d = data_i;

    // u = |z| / sqrt2 in Q28, far tail flagged
    if (STAGE == gcpb_pkg::STG_U) begin
      uprod  = 44'(data_i.mag) * 44'(gcpb_pkg::K_INV_SQRT2);
      ushift = 36'(uprod >> DIST_FRAC_BITS);
      data_d.big = ushift >= 36'(gcpb_pkg::U_LIMIT);
      data_d.u   = data_d.big ? '0 : ushift[30:0];
    end

    // divisor, u^2, divider and Horner seed
    if (STAGE == gcpb_pkg::STG_DENOM) begin
      pu = 61'(gcpb_pkg::K_P) * 61'(data_i.u);
      data_d.denom = 30'(gcpb_pkg::ONE_Q) + 30'(pu >> gcpb_pkg::FRAC);
      sq = 62'(data_i.u) * 62'(data_i.u);
      data_d.v   = 34'(sq >> gcpb_pkg::FRAC);
      data_d.rem = 30'(1 << 27);
      data_d.quo = '0;
      data_d.q   = 32'(gcpb_pkg::K_A5);
    end

    // one restoring quotient bit of 2^56 / denom
    if (IsDiv) begin
      rs = {data_i.rem, 1'b0};
      if (rs >= {1'b0, data_i.denom}) begin
        data_d.rem = 30'(rs - {1'b0, data_i.denom});
        data_d.quo = {data_i.quo[27:0], 1'b1};
      end else begin
        data_d.rem = rs[29:0];
        data_d.quo = {data_i.quo[27:0], 1'b0};
      end
    end

    // w = v * log2(e)
    if (STAGE == gcpb_pkg::STG_LOG2E) begin
      wp = 63'(data_i.v) * 63'(gcpb_pkg::K_LOG2E);
      data_d.v = 34'(wp >> gcpb_pkg::FRAC);
    end

    // split w, g = frac * ln2, series seed
    if (STAGE == gcpb_pkg::STG_LN2) begin
      data_d.k = data_i.v[33:28];
      gp = 56'(data_i.v[27:0]) * 56'(gcpb_pkg::K_LN2);
      data_d.g    = 28'(gp >> gcpb_pkg::FRAC);
      data_d.term = 29'(gcpb_pkg::ONE_Q);
      data_d.sum  = 32'(gcpb_pkg::ONE_Q);
    end

    // Taylor term: multiply by g, then divide by n
    if (IsTay) begin
      if (TayMul) begin
        tp = 57'(data_i.term) * 57'(data_i.g);
        data_d.prod = 28'(tp >> gcpb_pkg::FRAC);
      end else begin
        rp = 61'(data_i.prod) * 61'(gcpb_pkg::RECIP[TayN]);
        nt = 29'(rp >> 32);
        data_d.term = nt;
        if ((TayN % 2) == 1) begin
          data_d.sum = data_i.sum - 32'(nt);
        end else begin
          data_d.sum = data_i.sum + 32'(nt);
        end
      end
    end

    // e = exp(-u^2)
    if (STAGE == gcpb_pkg::STG_EXP) begin
      if (data_i.big || (data_i.sum < 0)) begin
        data_d.e = '0;
      end else begin
        data_d.e = data_i.sum[28:0] >> data_i.k;
      end
    end

    // Horner step: magnitude product, then signed truncate and add; the final pair multiplies by e and forms 1 +/- y
    if (IsHorn) begin
      if (HornMul) begin
        x = (HornJ < 5) ? data_i.quo : data_i.e;
        qmag = data_i.q[31] ? 32'(-data_i.q) : 32'(data_i.q);
        data_d.m   = 61'(qmag) * 61'(x);
        data_d.msg = data_i.q[31];
      end else begin
        r   = 33'(data_i.m >> gcpb_pkg::FRAC);
        rsg = data_i.msg ? -$signed({1'b0, r}) : $signed({1'b0, r});
        if (HornJ < 4) begin
          data_d.q = 32'(rsg + 34'(gcpb_pkg::HORNER_ADD[HornAddIdx]));
        end else if (HornJ == 4) begin
          data_d.q = 32'(rsg);
        end else begin
          yv = 35'(gcpb_pkg::ONE_Q) - 35'(rsg);
          if (yv < 0) begin
            y = '0;
          end else if (yv > 35'(gcpb_pkg::ONE_Q)) begin
            y = 29'(gcpb_pkg::ONE_Q);
          end else begin
            y = yv[28:0];
          end
          data_d.p29 = data_i.neg ? 30'(gcpb_pkg::ONE_Q) - 30'(y)
                                  : 30'(gcpb_pkg::ONE_Q) + 30'(y);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/gaussian_cdf_pixel_blend_core.sv =====
// Top level: pixel blend by normal CDF weight, pipelined one pixel per cycle while the output does not stall.
//
// Takes one pixel transfer per clock while the output does not stall and
// returns one result per pixel, in order. The pipeline depth is set by the
// 29-step restoring divider for t = 1/(1+p*u), which runs in parallel with
// the 12-term exp series, followed by the six Horner and
// exp multiply steps, the weight rounding and the channel mix. Every stage
// holds its own valid bit; a stage moves when it is empty or the stage after
// it moves, so empty slots are squeezed out while a result waits on the
// output. Flags select the class: outside the box or in the inner band the
// original pixel passes, in the surround band the pixel is blended, any other
// pixel in the box takes the inpainted pixel. blend_weight is zero unless the
// pixel was blended.
module gaussian_cdf_pixel_blend_core #(
  parameter int DIST_FRAC_BITS = gcpb_pkg::DIST_FRAC_BITS,
  parameter int WEIGHT_BITS    = gcpb_pkg::WEIGHT_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  gcpb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output gcpb_pkg::out_t out_data_o
);

  localparam int NumRegs = gcpb_pkg::STG_LAST + 3;
  localparam int WgtReg  = gcpb_pkg::STG_LAST + 1;
  localparam int OutReg  = gcpb_pkg::STG_LAST + 2;
  localparam int WideW   = WEIGHT_BITS + 31;
  localparam int AccW    = WEIGHT_BITS + 10;

  logic [NumRegs-1:0] vld;
  logic [NumRegs-1:0] en;
  gcpb_pkg::st_t      st [0:gcpb_pkg::STG_LAST];

  gcpb_pkg::st_t      in_d, in_q;
  logic               in_vld_q;

  logic [WEIGHT_BITS-1:0] wgt_d, wgt_q;
  gcpb_pkg::mode_e        wmode_q;
  gcpb_pkg::pix_t         worig_q, wfill_q;
  logic                   wvld_q;

  gcpb_pkg::out_t         out_d, out_q;
  gcpb_pkg::mode_e        omode_q;
  logic                   ovld_q;

  // Stage advance: empty, or the next one advances
  assign en[NumRegs-1] = !vld[NumRegs-1] || !out_stall_i;
  for (genvar k = 0; k < NumRegs - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end
  assign in_stall_o = !en[0];

  // Input capture: class decode and |z|
  always_comb begin
    in_d      = '0;
    in_d.orig = '{blue: in_data_i.orig_blue, green: in_data_i.orig_green,
                  red: in_data_i.orig_red};
    in_d.fill = '{blue: in_data_i.fill_blue, green: in_data_i.fill_green,
                  red: in_data_i.fill_red};
    in_d.neg  = in_data_i.distance_z[15];
    in_d.mag  = in_d.neg ? 16'(-in_data_i.distance_z) : 16'(in_data_i.distance_z);
    if (!in_data_i.inside_box || (in_data_i.band_flag && in_data_i.region_flag)) begin
      in_d.mode = gcpb_pkg::MODE_ORIG;
    end else if (in_data_i.band_flag) begin
      in_d.mode = gcpb_pkg::MODE_BLEND;
    end else begin
      in_d.mode = gcpb_pkg::MODE_FILL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en[0]) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      in_q <= in_d;
    end
  end

  assign vld[0] = in_vld_q;
  assign st[0]  = in_q;

  // Weight pipeline
  for (genvar s = 1; s <= gcpb_pkg::STG_LAST; s++) begin : g_stage
    gcpb_stage #(
      .STAGE          (s),
      .DIST_FRAC_BITS (DIST_FRAC_BITS)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[s]),
      .valid_i (vld[s-1]),
      .data_i  (st[s-1]),
      .valid_o (vld[s]),
      .data_o  (st[s])
    );
  end

  // Weight rounding to Q0.WEIGHT_BITS with saturation
  always_comb begin
    logic [WideW-1:0] wide;
    wide = ((WideW'(st[gcpb_pkg::STG_LAST].p29) << WEIGHT_BITS)
            + (WideW'(1) << 28)) >> 29;
    if (wide[WEIGHT_BITS]) begin
      wgt_d = '1;
    end else begin
      wgt_d = wide[WEIGHT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvld_q <= 1'b0;
    end else if (en[WgtReg]) begin
      wvld_q <= vld[gcpb_pkg::STG_LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[WgtReg] && vld[gcpb_pkg::STG_LAST]) begin
      wgt_q   <= wgt_d;
      wmode_q <= st[gcpb_pkg::STG_LAST].mode;
      worig_q <= st[gcpb_pkg::STG_LAST].orig;
      wfill_q <= st[gcpb_pkg::STG_LAST].fill;
    end
  end

  assign vld[WgtReg] = wvld_q;

  // orig*w + fill*(1-w), rounded, saturated
  function automatic logic [7:0] mix(logic [7:0] o, logic [7:0] f,
                                     logic [WEIGHT_BITS-1:0] w);
    logic [AccW-1:0] acc;
    logic [AccW-1:0] res;
    acc = AccW'(o) * AccW'(w)
        + AccW'(f) * ((AccW'(1) << WEIGHT_BITS) - AccW'(w))
        + (AccW'(1) << (WEIGHT_BITS - 1));
    res = acc >> WEIGHT_BITS;
    return (res > AccW'(255)) ? 8'hff : res[7:0];
  endfunction

  // Output select
  always_comb begin
    out_d = '0;
    case (wmode_q)
      gcpb_pkg::MODE_BLEND: begin
        out_d.out_blue     = mix(worig_q.blue, wfill_q.blue, wgt_q);
        out_d.out_green    = mix(worig_q.green, wfill_q.green, wgt_q);
        out_d.out_red      = mix(worig_q.red, wfill_q.red, wgt_q);
        out_d.blend_weight = 16'(wgt_q);
      end
      gcpb_pkg::MODE_FILL: begin
        out_d.out_blue  = wfill_q.blue;
        out_d.out_green = wfill_q.green;
        out_d.out_red   = wfill_q.red;
      end
      default: begin
        out_d.out_blue  = worig_q.blue;
        out_d.out_green = worig_q.green;
        out_d.out_red   = worig_q.red;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (en[OutReg]) begin
      ovld_q <= wvld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OutReg] && wvld_q) begin
      out_q   <= out_d;
      omode_q <= wmode_q;
    end
  end

  assign vld[OutReg] = ovld_q;
  assign out_valid_o = ovld_q;
  assign out_data_o  = out_q;

  // Input stalls only when every stage is occupied
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vld == '1))
    else $error("input stalled with an empty pipeline slot");

  // An input transfer lands in the first stage
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld[0])
    else $error("accepted pixel lost at input register");

  // Nonzero weight only on blended pixels
  a_weight_blend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.blend_weight != 16'd0))
      |-> (omode_q == gcpb_pkg::MODE_BLEND))
    else $error("weight reported on a pixel that was not blended");

endmodule
